@@ design/sop_pkg.sv @@
// Package for the suffix/prefix overlap block: field widths and the search state type.
// No dependencies; imported by every module of the block.
`default_nettype none

package sop_pkg;

  localparam int unsigned SYM_W = 8;
  localparam int unsigned OVL_W = 9;
  localparam int unsigned OUT_TDATA_W = 16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_DONE
  } sop_state_e;

endpackage

`default_nettype wire

@@ design/sop_buf.sv @@
// Symbol buffer for one read: one write port, one read port, registered read data.
// Depends on sop_pkg for the symbol width.
`default_nettype none

module sop_buf #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [AW-1:0]            waddr_i,
  input  wire logic [sop_pkg::SYM_W-1:0] wdata_i,
  input  wire logic [AW-1:0]            raddr_i,
  output logic      [sop_pkg::SYM_W-1:0] rdata_o
);
  import sop_pkg::*;

  logic [SYM_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ design/suffix_prefix_overlap.sv @@
// Top level of the suffix/prefix overlap block: load control, overlap search, output register.
// Depends on sop_pkg and sop_buf (two instances, one per read).
//
//  channel  | dir | tdata                  | tuser          | tlast
//  s_axis   | in  | [7:0] symbol           | [0] which_read | end_of_read
//  m_axis   | out | [8:0] overlap_length   | [0] truncated  | -
//  cfg      | in  | [8:0] min_overlap      | -              | -
//
// Symbols load at one beat per cycle while s_axis_tready is high. After the last beat of read B
// the search walks the buffers, with a memory read and then a compare for each symbol compared,
// trying lengths from min(len A, len B) down to min_overlap.
// s_axis_tready is low from B's last beat until the result enters the output register;
// that register holds a result while later symbols keep loading.
// Reset clears the read lengths and load flags and empties the output register; buffer contents are not cleared.
`default_nettype none

module suffix_prefix_overlap #(
  parameter int unsigned MAX_LEN = 256
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [sop_pkg::OVL_W-1:0]     cfg_wdata_i,     // [8:0] min_overlap
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [sop_pkg::SYM_W-1:0]     s_axis_tdata,    // [7:0] symbol
  input  wire logic                          s_axis_tuser,    // [0] which_read
  input  wire logic                          s_axis_tlast,    // end_of_read
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [sop_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,    // [8:0] overlap_length
  output logic                               m_axis_tuser     // [0] truncated
);
  import sop_pkg::*;

  localparam int unsigned LW = $clog2(MAX_LEN + 1);
  localparam int unsigned AW = $clog2(MAX_LEN);
  localparam int unsigned CW = (LW > OVL_W) ? LW : OVL_W;
  localparam logic [LW-1:0] MaxLen = LW'(MAX_LEN);

  sop_state_e state_q, state_d;

  logic [OVL_W-1:0] min_q;
  logic [LW-1:0]    len_a_q, len_a_d;
  logic [LW-1:0]    len_b_q, len_b_d;
  logic             a_cmpl_q, a_cmpl_d;
  logic             ovf_q, ovf_d;
  logic             a_drop_q, a_drop_d;

  logic [LW-1:0]    len_q, len_d;
  logic [LW-1:0]    idx_q, idx_d;
  logic [LW-1:0]    res_q, res_d;
  logic             trunc_q, trunc_d;

  logic             out_vld_q, out_vld_d;
  logic [OVL_W-1:0] out_len_q, out_len_d;
  logic             out_trunc_q, out_trunc_d;

  logic                we_a, we_b;
  logic [AW-1:0]       waddr_a, waddr_b;
  logic [AW-1:0]       raddr_a, raddr_b;
  logic [SYM_W-1:0]    rdata_a, rdata_b;

  logic             accept;
  logic             a_fits, b_fits;
  logic [LW-1:0]    a_base;
  logic [LW-1:0]    lb_new;
  logic [LW-1:0]    top;
  logic [OVL_W-1:0] low;
  logic [LW-1:0]    a_rd;
  logic [LW-1:0]    idx_inc;
  logic [LW-1:0]    len_dec;
  logic [CW-1:0]    res_ext;

  assign accept  = s_axis_tvalid && s_axis_tready;
  assign low     = (min_q == '0) ? OVL_W'(1) : min_q;
  assign a_base  = a_cmpl_q ? '0 : len_a_q;
  assign a_fits  = a_base < MaxLen;
  assign b_fits  = len_b_q < MaxLen;
  assign lb_new  = b_fits ? len_b_q + LW'(1) : len_b_q;
  assign top     = (len_a_q < lb_new) ? len_a_q : lb_new;
  assign a_rd    = len_a_q - len_q + idx_q;
  assign idx_inc = idx_q + LW'(1);
  assign len_dec = len_q - LW'(1);
  assign res_ext = CW'(res_q);

  assign we_a    = accept && !s_axis_tuser && a_fits;
  assign we_b    = accept && s_axis_tuser && b_fits;
  assign waddr_a = a_base[AW-1:0];
  assign waddr_b = len_b_q[AW-1:0];
  assign raddr_a = a_rd[AW-1:0];
  assign raddr_b = idx_q[AW-1:0];

  sop_buf #(.DEPTH(MAX_LEN), .AW(AW)) u_buf_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr_a),
    .wdata_i (s_axis_tdata),
    .raddr_i (raddr_a),
    .rdata_o (rdata_a)
  );

  sop_buf #(.DEPTH(MAX_LEN), .AW(AW)) u_buf_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr_b),
    .wdata_i (s_axis_tdata),
    .raddr_i (raddr_b),
    .rdata_o (rdata_b)
  );

  always_comb begin
    state_d     = state_q;
    len_a_d     = len_a_q;
    len_b_d     = len_b_q;
    a_cmpl_d    = a_cmpl_q;
    ovf_d       = ovf_q;
    a_drop_d    = a_drop_q;
    len_d       = len_q;
    idx_d       = idx_q;
    res_d       = res_q;
    trunc_d     = trunc_q;
    out_vld_d   = out_vld_q && !m_axis_tready;
    out_len_d   = out_len_q;
    out_trunc_d = out_trunc_q;
    s_axis_tready = 1'b0;

    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (accept) begin
          if (!s_axis_tuser) begin
            len_a_d  = a_fits ? a_base + LW'(1) : MaxLen;
            a_drop_d = (a_cmpl_q ? 1'b0 : a_drop_q) | !a_fits;
            ovf_d    = (a_cmpl_q ? 1'b0 : ovf_q) | !a_fits;
            a_cmpl_d = s_axis_tlast;
          end else if (!s_axis_tlast) begin
            len_b_d = lb_new;
            ovf_d   = ovf_q | !b_fits;
          end else begin
            len_b_d = '0;
            trunc_d = ovf_q | !b_fits | a_drop_q;
            ovf_d   = a_drop_q;
            len_d   = top;
            idx_d   = '0;
            if (CW'(top) >= CW'(low)) begin
              state_d = ST_READ;
            end else begin
              res_d   = '0;
              state_d = ST_DONE;
            end
          end
        end
      end
      ST_READ: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (rdata_a == rdata_b) begin
          if (idx_inc == len_q) begin
            res_d   = len_q;
            state_d = ST_DONE;
          end else begin
            idx_d   = idx_inc;
            state_d = ST_READ;
          end
        end else begin
          idx_d = '0;
          len_d = len_dec;
          if (len_dec == '0 || CW'(len_dec) < CW'(low)) begin
            res_d   = '0;
            state_d = ST_DONE;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_DONE: begin
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d   = 1'b1;
          out_len_d   = res_ext[OVL_W-1:0];
          out_trunc_d = trunc_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      min_q     <= OVL_W'(1);
      len_a_q   <= '0;
      len_b_q   <= '0;
      a_cmpl_q  <= 1'b0;
      ovf_q     <= 1'b0;
      a_drop_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      if (cfg_we_i) begin
        min_q <= cfg_wdata_i;
      end
      len_a_q   <= len_a_d;
      len_b_q   <= len_b_d;
      a_cmpl_q  <= a_cmpl_d;
      ovf_q     <= ovf_d;
      a_drop_q  <= a_drop_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q       <= len_d;
    idx_q       <= idx_d;
    res_q       <= res_d;
    trunc_q     <= trunc_d;
    out_len_q   <= out_len_d;
    out_trunc_q <= out_trunc_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OUT_TDATA_W'(out_len_q);
  assign m_axis_tuser  = out_trunc_q;

endmodule

`default_nettype wire
